@@ design/zsep_pkg.sv @@
// ----------------------------------------------------------------------------
// zsep_pkg: shared types and constants
// Result record, parser phases and status codes for the stored-entry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package zsep_pkg;

  localparam logic [31:0] CrcPoly   = 32'hedb88320;
  localparam logic [31:0] CrcOnes   = 32'hffffffff;
  localparam logic [31:0] LocalSig  = 32'h04034b50;
  localparam logic [4:0]  HdrLast   = 5'd29;
  localparam int unsigned MaxRes    = 3;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_UNSUP   = 3'd2,
    ST_CRC     = 3'd3,
    ST_ENTRIES = 3'd4,
    ST_SIZE    = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  typedef enum logic [6:0] {
    PH_SIGNATURE = 7'b0000001,
    PH_HEADER    = 7'b0000010,
    PH_NAME      = 7'b0000100,
    PH_EXTRA     = 7'b0001000,
    PH_DATA      = 7'b0010000,
    PH_STOPPED   = 7'b0100000,
    PH_FAILED    = 7'b1000000
  } phase_e;

  typedef enum logic {
    REG_BYTE_LIMIT  = 1'b0,
    REG_MAX_ENTRIES = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [15:0] entry_number;
    status_e     status;
    logic        last_of_run;
  } zsep_res_t;

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic zsep_res_t mk_res(input kind_e k, input logic [7:0] v,
                                       input logic [15:0] e, input status_e s);
    zsep_res_t r;
    r.kind         = k;
    r.value        = v;
    r.entry_number = e;
    r.status       = s;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/zsep_parser.sv @@
// ----------------------------------------------------------------------------
// zsep_parser: front end
// Parses one archive byte per cycle while take_i is high and produces up to three result items.
// ----------------------------------------------------------------------------
`default_nettype none

module zsep_parser (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    take_i,
  input  wire  [7:0]             data_byte_i,
  input  wire                    end_of_archive_i,
  input  wire  [31:0]            byte_limit_i,
  input  wire  [15:0]            max_entries_i,
  output logic [1:0]             res_cnt_o,
  output zsep_pkg::zsep_res_t    res_o [zsep_pkg::MaxRes]
);
  import zsep_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] exp_crc_q, exp_crc_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] name_q, name_d;
  logic [15:0] extra_q, extra_d;
  logic [31:0] data_q, data_d;
  logic [15:0] ec_q, ec_d;
  logic [32:0] ab_q, ab_d;
  logic [32:0] et_q, et_d;
  logic        bad_q, bad_d;
  logic        do_next;
  logic [1:0]  n;
  zsep_res_t   res [MaxRes];

  // next state and results for one byte
  always_comb begin
    phase_d = phase_q; pos_d = pos_q; shift_d = shift_q; exp_crc_d = exp_crc_q;
    crc_d = crc_q; name_d = name_q; extra_d = extra_q; data_d = data_q;
    ec_d = ec_q; et_d = et_q; bad_d = bad_q;
    do_next = 1'b0;
    n = 2'd0;
    for (int k = 0; k < MaxRes; k++) res[k] = mk_res(KIND_NAME, 8'd0, 16'd0, ST_OK);

    ab_d = (ab_q != {33{1'b1}}) ? ab_q + 33'd1 : ab_q;
    shift_d = {data_byte_i, shift_q[63:8]};

    if (phase_q != PH_FAILED) begin
      if (ab_d > {1'b0, byte_limit_i}) begin
        phase_d = PH_FAILED;
        if (n != 2'd3) begin res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_SIZE); n = n + 2'd1; end
      end else begin
        unique case (phase_q)
          PH_SIGNATURE: begin
            if (pos_q < 5'd3) begin
              pos_d = pos_q + 5'd1;
            end else if (shift_d[63:32] != LocalSig) begin
              pos_d = 5'd0;
              phase_d = PH_STOPPED;
            end else if (ec_q >= max_entries_i) begin
              pos_d = 5'd0;
              phase_d = PH_FAILED;
              if (n != 2'd3) begin
                res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_ENTRIES); n = n + 2'd1;
              end
            end else begin
              pos_d = 5'd4;
              bad_d = 1'b0;
              phase_d = PH_HEADER;
            end
          end
          PH_HEADER: begin
            // header fields land as their last byte arrives
            unique case (pos_q)
              5'd9:  if (shift_d[63:32] != 32'd0) bad_d = 1'b1;
              5'd17: exp_crc_d = shift_d[63:32];
              5'd21: data_d = shift_d[63:32];
              5'd25: if (shift_d[63:32] != data_d) bad_d = 1'b1;
              5'd27: name_d = shift_d[63:48];
              5'd29: extra_d = shift_d[63:48];
              default: ;
            endcase
            if (pos_q < HdrLast) begin
              pos_d = pos_q + 5'd1;
            end else begin
              pos_d = 5'd0;
              if (bad_d) begin
                phase_d = PH_FAILED;
                if (n != 2'd3) begin
                  res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_UNSUP); n = n + 2'd1;
                end
              end else begin
                et_d = et_q + {1'b0, data_d};
                if (et_d > {1'b0, byte_limit_i}) begin
                  phase_d = PH_FAILED;
                  if (n != 2'd3) begin
                    res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_SIZE); n = n + 2'd1;
                  end
                end else begin
                  crc_d = CrcOnes;
                  do_next = 1'b1;
                end
              end
            end
          end
          PH_NAME: begin
            if (n != 2'd3) begin
              res[n] = mk_res(KIND_NAME, data_byte_i, ec_d, ST_OK); n = n + 2'd1;
            end
            name_d = name_q - 16'd1;
            do_next = 1'b1;
          end
          PH_EXTRA: begin
            extra_d = extra_q - 16'd1;
            do_next = 1'b1;
          end
          PH_DATA: begin
            if (n != 2'd3) begin
              res[n] = mk_res(KIND_DATA, data_byte_i, ec_d, ST_OK); n = n + 2'd1;
            end
            crc_d = crc_byte(crc_q, data_byte_i);
            data_d = data_q - 32'd1;
            do_next = 1'b1;
          end
          default: ;
        endcase

        // move to the next section or close the entry
        if (do_next) begin
          priority if (name_d != 16'd0) begin
            phase_d = PH_NAME;
          end else if (extra_d != 16'd0) begin
            phase_d = PH_EXTRA;
          end else if (data_d != 32'd0) begin
            phase_d = PH_DATA;
          end else if (~crc_d != exp_crc_d) begin
            if (n != 2'd3) begin
              res[n] = mk_res(KIND_ENTRY, 8'd0, ec_d, ST_CRC); n = n + 2'd1;
            end
            phase_d = PH_FAILED;
            if (n != 2'd3) begin
              res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_CRC); n = n + 2'd1;
            end
          end else begin
            if (n != 2'd3) begin
              res[n] = mk_res(KIND_ENTRY, 8'd0, ec_d, ST_OK); n = n + 2'd1;
            end
            ec_d = ec_q + 16'd1;
            phase_d = PH_SIGNATURE;
            pos_d = 5'd0;
          end
        end
      end
    end

    // final byte: archive end and return to reset state
    if (end_of_archive_i) begin
      if (phase_d == PH_SIGNATURE || phase_d == PH_STOPPED) begin
        if (n != 2'd3) begin
          res[n] = mk_res(KIND_END, 8'd0, ec_d, (ec_d != 16'd0) ? ST_OK : ST_EMPTY);
          n = n + 2'd1;
        end
      end else if (phase_d != PH_FAILED) begin
        if (n != 2'd3) begin res[n] = mk_res(KIND_END, 8'd0, ec_d, ST_TRUNC); n = n + 2'd1; end
      end
      phase_d = PH_SIGNATURE; pos_d = 5'd0; shift_d = 64'd0; exp_crc_d = 32'd0;
      crc_d = CrcOnes; name_d = 16'd0; extra_d = 16'd0; data_d = 32'd0;
      ec_d = 16'd0; ab_d = 33'd0; et_d = 33'd0; bad_d = 1'b0;
    end

    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
  end

  assign res_cnt_o = take_i ? n : 2'd0;
  assign res_o = res;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGNATURE; pos_q <= 5'd0; shift_q <= 64'd0; exp_crc_q <= 32'd0;
      crc_q <= CrcOnes; name_q <= 16'd0; extra_q <= 16'd0; data_q <= 32'd0;
      ec_q <= 16'd0; ab_q <= 33'd0; et_q <= 33'd0; bad_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; pos_q <= pos_d; shift_q <= shift_d; exp_crc_q <= exp_crc_d;
      crc_q <= crc_d; name_q <= name_d; extra_q <= extra_d; data_q <= data_d;
      ec_q <= ec_d; ab_q <= ab_d; et_q <= et_d; bad_q <= bad_d;
    end
  end

endmodule

`default_nettype wire

@@ design/zsep_queue.sv @@
// ----------------------------------------------------------------------------
// zsep_queue: back end result queue
// Takes up to three items per cycle from the parser, hands out one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module zsep_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  [1:0]             wr_cnt_i,
  input  wire zsep_pkg::zsep_res_t wr_data_i [zsep_pkg::MaxRes],
  input  wire                    pop_i,
  output zsep_pkg::zsep_res_t    head_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import zsep_pkg::*;

  localparam int unsigned Depth = 8;

  zsep_res_t   mem_q [Depth];
  logic [2:0]  wr_ptr_q, rd_ptr_q;
  logic [3:0]  cnt_q;
  logic        rd;

  assign empty_o = (cnt_q == 4'd0);
  // room for a whole run of results
  assign full_o  = (cnt_q > 4'(Depth - MaxRes));
  assign rd      = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < wr_cnt_i) mem_q[wr_ptr_q + 3'(k)] <= wr_data_i[k];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 3'd0;
      rd_ptr_q <= 3'd0;
      cnt_q    <= 4'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + {1'b0, wr_cnt_i};
      rd_ptr_q <= rd_ptr_q + {2'd0, rd};
      cnt_q    <= cnt_q + {2'd0, wr_cnt_i} - {3'd0, rd};
    end
  end

endmodule

`default_nettype wire

@@ design/zip_stored_entry_parser_core.sv @@
// ----------------------------------------------------------------------------
// zip_stored_entry_parser_core: stored zip entry parser with crc-32 check
// Parses local headers, passes name and data bytes, reports entry and archive end.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          data_byte_i, end_of_archive_i
//  result    empty / pop          kind_o, value_o, entry_number_o, status_o, last_of_run_o
//  config    cfg_valid / ready    cfg_index_i, cfg_data_i
//
//  one byte is parsed in the cycle it is accepted; its results enter the queue
//  at that edge and the oldest shows on the result ports the cycle after
//  an item makes up to three results; the queue drains one result per cycle while pop is high
//  full rises when the 8-entry queue has fewer than three free slots
//  reset clears all parser state and the queue; config resets to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module zip_stored_entry_parser_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte_i,
  input  wire         end_of_archive_i,
  output logic        empty,
  input  wire         pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [15:0] entry_number_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import zsep_pkg::*;

  logic [31:0] byte_limit_q;
  logic [15:0] max_entries_q;
  logic        take;
  logic [1:0]  res_cnt;
  zsep_res_t   res [MaxRes];
  zsep_res_t   head;

  assign cfg_ready_o = 1'b1;
  assign take = push && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q  <= 32'hffffffff;
      max_entries_q <= 16'd1024;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_BYTE_LIMIT:  byte_limit_q  <= cfg_data_i;
        REG_MAX_ENTRIES: max_entries_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  zsep_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .data_byte_i      (data_byte_i),
    .end_of_archive_i (end_of_archive_i),
    .byte_limit_i     (byte_limit_q),
    .max_entries_i    (max_entries_q),
    .res_cnt_o        (res_cnt),
    .res_o            (res)
  );

  zsep_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_cnt_i  (res_cnt),
    .wr_data_i (res),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty),
    .full_o    (full)
  );

  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign entry_number_o = head.entry_number;
  assign status_o       = head.status;
  assign last_of_run_o  = head.last_of_run;

  // byte results always carry ok status
  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_NAME || kind_o == KIND_DATA)) |-> status_o == ST_OK)
    else $error("byte result with nonzero status");

  // end results carry a zero value
  a_end_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == KIND_ENTRY || kind_o == KIND_END)) |-> value_o == 8'd0)
    else $error("end result with nonzero value");

  // an entry end reports only ok or crc mismatch
  a_entry_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_ENTRY) |-> (status_o == ST_OK || status_o == ST_CRC))
    else $error("bad entry end status");

endmodule

`default_nettype wire

@@ sim/zip_stored_entry_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// zip_stored_entry_parser_core_tb: self-checking bench for the stored-entry parser
// Streams built zip archives (good entries, broken headers, bad crc, truncation,
// trailing noise) through the core under several limit settings, predicts every
// result with an in-bench model of the parser and compares each popped result.
// ----------------------------------------------------------------------------
`default_nettype none

module zip_stored_entry_parser_core_tb;
  import zsep_pkg::*;

  localparam int FL_NONE   = 0;
  localparam int FL_FLAGS  = 1;
  localparam int FL_METHOD = 2;
  localparam int FL_SIZES  = 3;
  localparam int FL_CRC    = 4;
  localparam int FL_HUGE   = 5;

  // result predictor and scoreboard
  class parse_scoreboard;
    logic [31:0] byte_limit;
    logic [15:0] max_entries;
    phase_e      ph;
    logic [4:0]  hdr_pos;
    logic [63:0] shift;
    logic [31:0] crc_want;
    logic [31:0] crc_run;
    logic [15:0] name_left;
    logic [15:0] extra_left;
    logic [31:0] data_left;
    logic [15:0] entries;
    logic [32:0] arc_bytes;
    logic [32:0] total;
    bit          hdr_bad;
    zsep_res_t   run[$];
    zsep_res_t   pending[$];
    int          mismatches;
    int          checked;
    int          archives;

    function new();
      byte_limit  = 32'hffffffff;
      max_entries = 16'd1024;
      mismatches  = 0;
      checked     = 0;
      archives    = 0;
      clear();
    endfunction

    function void clear();
      ph         = PH_SIGNATURE;
      hdr_pos    = '0;
      shift      = '0;
      crc_want   = '0;
      crc_run    = 32'hffffffff;
      name_left  = '0;
      extra_left = '0;
      data_left  = '0;
      entries    = '0;
      arc_bytes  = '0;
      total      = '0;
      hdr_bad    = 1'b0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) x = (x >> 1) ^ (x[0] ? 32'hedb88320 : 32'd0);
      return x;
    endfunction

    function void emit(kind_e k, logic [7:0] v, status_e s);
      zsep_res_t r;
      if (run.size() >= 3) return;
      r.kind         = k;
      r.value        = v;
      r.entry_number = entries;
      r.status       = s;
      r.last_of_run  = 1'b0;
      run.insert(run.size(), r);
    endfunction

    function void fail(status_e s);
      ph = PH_FAILED;
      emit(KIND_END, 8'd0, s);
    endfunction

    function void next_section();
      if (name_left != 0) ph = PH_NAME;
      else if (extra_left != 0) ph = PH_EXTRA;
      else if (data_left != 0) ph = PH_DATA;
      else if (~crc_run != crc_want) begin
        emit(KIND_ENTRY, 8'd0, ST_CRC);
        fail(ST_CRC);
      end else begin
        emit(KIND_ENTRY, 8'd0, ST_OK);
        entries = entries + 16'd1;
        ph      = PH_SIGNATURE;
        hdr_pos = '0;
      end
    endfunction

    // one header byte; fields are taken from the top of the shift window
    function void header_step();
      case (hdr_pos)
        5'd9:  if (shift[63:32] != 0) hdr_bad = 1'b1;
        5'd17: crc_want = shift[63:32];
        5'd21: data_left = shift[63:32];
        5'd25: if (shift[63:32] != data_left) hdr_bad = 1'b1;
        5'd27: name_left = shift[63:48];
        5'd29: extra_left = shift[63:48];
        default: ;
      endcase
      if (hdr_pos != 5'd29) begin
        hdr_pos++;
        return;
      end
      hdr_pos = '0;
      if (hdr_bad) begin
        fail(ST_UNSUP);
        return;
      end
      total = total + {1'b0, data_left};
      if (total > {1'b0, byte_limit}) begin
        fail(ST_SIZE);
        return;
      end
      crc_run = 32'hffffffff;
      next_section();
    endfunction

    // note an accepted input item and queue what it causes
    function void note(logic [7:0] b, logic last);
      run.delete();
      if (arc_bytes != '1) arc_bytes++;
      if (ph != PH_FAILED) begin
        if (arc_bytes > {1'b0, byte_limit}) fail(ST_SIZE);
        else begin
          shift = {b, shift[63:8]};
          case (ph)
            PH_SIGNATURE: begin
              if (hdr_pos < 3) hdr_pos++;
              else if (shift[63:32] != 32'h04034b50) begin
                hdr_pos = '0;
                ph      = PH_STOPPED;
              end else if (entries >= max_entries) begin
                hdr_pos = '0;
                fail(ST_ENTRIES);
              end else begin
                hdr_pos = 5'd4;
                hdr_bad = 1'b0;
                ph      = PH_HEADER;
              end
            end
            PH_HEADER: header_step();
            PH_NAME: begin
              emit(KIND_NAME, b, ST_OK);
              name_left--;
              next_section();
            end
            PH_EXTRA: begin
              extra_left--;
              next_section();
            end
            PH_DATA: begin
              emit(KIND_DATA, b, ST_OK);
              crc_run = crc_step(crc_run, b);
              data_left--;
              next_section();
            end
            default: ;
          endcase
        end
      end
      if (last) begin
        if ((ph == PH_SIGNATURE && hdr_pos < 4) || ph == PH_STOPPED)
          emit(KIND_END, 8'd0, entries != 0 ? ST_OK : ST_EMPTY);
        else if (ph != PH_FAILED)
          emit(KIND_END, 8'd0, ST_TRUNC);
        clear();
        archives++;
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) pending.insert(pending.size(), run[i]);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // compare one popped result with the oldest expectation
    task check(zsep_res_t got);
      zsep_res_t w;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result kind", 32'(got.kind), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) report("kind", 32'(got.kind), 32'(w.kind));
      if (got.value != w.value) report("value", 32'(got.value), 32'(w.value));
      if (got.entry_number != w.entry_number)
        report("entry_number", 32'(got.entry_number), 32'(w.entry_number));
      if (got.status != w.status) report("status", 32'(got.status), 32'(w.status));
      if (got.last_of_run != w.last_of_run)
        report("last_of_run", 32'(got.last_of_run), 32'(w.last_of_run));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_archive_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  value_o;
  logic [15:0] entry_number_o;
  logic [2:0]  status_o;
  logic        last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  parse_scoreboard sb = new();
  logic [7:0] arc_q[$];
  bit         send_idle = 1'b1;
  int         sent = 0;
  int         hold_at = -1;

  zip_stored_entry_parser_core DUT (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .end_of_archive_i,
    .empty, .pop, .kind_o, .value_o, .entry_number_o, .status_o, .last_of_run_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    zsep_res_t r;
    if (rst_ni && pop && !empty) begin
      r.kind         = kind_e'(kind_o);
      r.value        = value_o;
      r.entry_number = entry_number_o;
      r.status       = status_e'(status_o);
      r.last_of_run  = last_of_run_o;
      sb.check(r);
    end
  end

  // receiver: random stalls with bursts of none
  initial begin
    int gap;
    int n;
    bit stall_on;
    stall_on = 1'b1;
    n = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (++n % 40 == 0) stall_on = !stall_on;
      gap = stall_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push             <= 1'b1;
    data_byte_i      <= b;
    end_of_archive_i <= last;
    do @(posedge clk_i); while (full);
    sb.note(b, last);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    drain();
    repeat (6) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BYTE_LIMIT) sb.byte_limit = val;
    else sb.max_entries = val[15:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic put8(logic [7:0] v);
    arc_q.insert(arc_q.size(), v);
  endtask

  task automatic put16(logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  // append one local header with its name, extra field and data (no data bytes for FL_HUGE)
  task automatic add_entry(int nlen, int elen, int dlen, int flaw);
    logic [7:0]  d[$];
    logic [31:0] crc;
    logic [31:0] usize;
    crc = 32'hffffffff;
    for (int i = 0; i < dlen; i++) begin
      d.insert(d.size(), 8'($urandom_range(0, 255)));
      crc = sb.crc_step(crc, d[i]);
    end
    crc   = ~crc;
    usize = 32'(dlen);
    if (flaw == FL_HUGE) usize = 32'hffffff00 | $urandom_range(0, 255);
    put32(32'h04034b50);
    put16(16'($urandom_range(0, 65535)));
    put16(flaw == FL_FLAGS ? 16'd1 << $urandom_range(0, 15) : 16'd0);
    put16(flaw == FL_METHOD ? 16'd1 << $urandom_range(0, 15) : 16'd0);
    put32($urandom);
    put32(flaw == FL_CRC ? crc ^ (32'd1 << $urandom_range(0, 31)) : crc);
    put32(usize);
    put32(flaw == FL_SIZES ? usize ^ (32'd1 << $urandom_range(0, 31)) : usize);
    put16(16'(nlen));
    put16(16'(elen));
    repeat (nlen) put8(8'($urandom_range(0, 255)));
    repeat (elen) put8(8'($urandom_range(0, 255)));
    if (flaw != FL_HUGE) foreach (d[i]) put8(d[i]);
  endtask

  task automatic send_archive();
    if (arc_q.size() == 0) put8(8'($urandom_range(0, 255)));
    foreach (arc_q[i]) begin
      if (i == hold_at) drain();
      send_byte(arc_q[i], i == arc_q.size() - 1);
    end
    arc_q.delete();
    hold_at = -1;
  endtask

  // random archive: mostly well-formed entries, some flaws, cuts and tails
  task automatic random_archive();
    int n;
    int pick;
    send_idle = $urandom_range(0, 3) != 0;
    n = $urandom_range(0, 3);
    for (int e = 0; e < n; e++) begin
      pick = $urandom_range(0, 9);
      add_entry($urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 6),
                pick < 7 ? FL_NONE : $urandom_range(FL_FLAGS, FL_HUGE));
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) repeat ($urandom_range(1, 3)) put8(8'($urandom_range(0, 255)));
    else if (pick < 4) repeat ($urandom_range(4, 8)) put8(8'($urandom_range(0, 255)));
    if (arc_q.size() > 1 && $urandom_range(0, 6) == 0)
      arc_q = arc_q[0:$urandom_range(0, arc_q.size() - 2)];
    send_archive();
  endtask

  task automatic random_phase(int items);
    int stop_at;
    stop_at = sent + items;
    while (sent < stop_at) random_archive();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty, short tail, non-signature stop, truncated header
    send_archive();
    repeat (3) put8(8'hff);
    send_archive();
    put32(32'h04034b51);
    put8(8'h00);
    send_archive();
    put32(32'h04034b50);
    put16(16'h0014);
    send_archive();
    // one clean entry with its name byte set to zero, held once mid-way
    add_entry(1, 1, 2, FL_NONE);
    arc_q[30] = 8'h00;
    hold_at = 31;
    send_archive();
    add_entry(0, 0, 1, FL_CRC);
    add_entry(0, 0, 0, FL_NONE);
    send_archive();
    add_entry(0, 0, 0, FL_FLAGS);
    send_archive();

    random_phase(40);
    write_reg(REG_BYTE_LIMIT, 32'd0);
    random_phase(10);
    write_reg(REG_BYTE_LIMIT, 32'd70);
    write_reg(REG_MAX_ENTRIES, 32'd1);
    random_phase(20);
    write_reg(REG_MAX_ENTRIES, 32'd65535);
    random_phase(20);
    write_reg(REG_BYTE_LIMIT, 32'hffffffff);
    write_reg(REG_MAX_ENTRIES, 32'd2);
    random_phase(20);

    drain();
    repeat (20) @(posedge clk_i);
    $display("parsed %0d archives from %0d bytes, %0d results checked",
             sb.archives, sent, sb.checked);
    $display("limits covered: byte limit 0, 70 and max; entry limit 1, 2, 1024, 65535");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("zip_stored_entry_parser_core_tb OK");
    else
      $display("zip_stored_entry_parser_core_tb NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("timeout at %0t", $time);
    $display("zip_stored_entry_parser_core_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
